// ----- sv/edr_pkg.sv -----
// ============================================================================
// edr_pkg
// Shared constants, types and phase codes of the DER-to-raw signature converter.
// ============================================================================
package edr_pkg;

  // Raw signature size: r and s halves, big-endian
  localparam int unsigned SigBytes  = 64;
  localparam int unsigned HalfBytes = SigBytes / 2;
  localparam int unsigned IdxW      = $clog2(SigBytes);
  // Two banks of raw store, one being filled while the other drains
  localparam int unsigned AddrW     = IdxW + 1;
  localparam int unsigned RamDepth  = 1 << AddrW;

  // DER codes
  localparam logic [7:0] TagSeq    = 8'h30;
  localparam logic [7:0] TagOctets = 8'h04;
  localparam logic [7:0] TagInt    = 8'h02;
  localparam logic [7:0] LongForm  = 8'h80;
  localparam logic [7:0] LenNibble = 8'h0F;

  // Parser phase
  typedef enum logic [3:0] {
    PH_OUT_TAG,
    PH_OUT_LEN,
    PH_SKIP_TAG,
    PH_SKIP_LEN,
    PH_SKIP_LENB,
    PH_OCT_TAG,
    PH_OCT_LEN,
    PH_IN_TAG,
    PH_IN_LEN,
    PH_R_TAG,
    PH_R_LEN,
    PH_R_BODY,
    PH_S_TAG,
    PH_S_LEN,
    PH_S_BODY,
    PH_END
  } phase_e;

  // One finished signature handed from parser to emitter
  typedef struct packed {
    logic            err;
    logic            bank;
    logic [IdxW-1:0] r_start;
    logic [IdxW-1:0] s_start;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } ram_rd_t;

endpackage

// ----- sv/ecdsa_der_to_raw_signature.sv -----
// ============================================================================
// ecdsa_der_to_raw_signature
// Converts a wrapped DER ECDSA signature, one byte per transaction, into the
// raw r||s form, or one error item when the encoding is malformed.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o| in_byte_i, in_last_i
//  out     | output    | out_valid_o/out_ready_i | out_byte_o, out_last_o, status_o
//
//  Input: one byte per cycle while in_ready_o is high; each byte is parsed
//  as it is taken. Output: 64 bytes (or one error item) per signature, one
//  per cycle while out_ready_i is high; the first passes through the job
//  queue, the registered read of the raw store RAM and the output register.
//  Input stalls only while two finished signatures wait, as the store has
//  two banks; the parser fills one while the emitter drains the other.
//  Reset needs no clearing pass: padding bytes are produced from the
//  recorded start indexes of r and s, never read from the store.
// ============================================================================
module ecdsa_der_to_raw_signature (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       status_o
);
  import edr_pkg::*;

  logic    job_push, job_pop, job_full, job_valid;
  job_t    job_in, job_head;
  ram_wr_t wr;
  ram_rd_t rd;
  logic [7:0] rdata;

  // Front end
  edr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .wr_o       (wr)
  );

  // Queue of finished signatures
  edr_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .full_o  (job_full),
    .valid_o (job_valid),
    .head_o  (job_head)
  );

  // Two-bank raw store
  edr_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rdata)
  );

  // Back end
  edr_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .rd_o        (rd),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o)
  );

endmodule

// ----- sv/edr_ram.sv -----
// ============================================================================
// edr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module edr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/edr_parser.sv -----
// ============================================================================
// edr_parser
// Front end: walks the DER headers byte by byte, writes integer bytes into
// the current bank and queues one job per signature on the last byte.
// ============================================================================
module edr_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  input  logic           job_full_i,
  output logic           job_push_o,
  output edr_pkg::job_t  job_o,
  output edr_pkg::ram_wr_t wr_o
);
  import edr_pkg::*;

  phase_e          phase_q, phase_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     acc_q, acc_d;
  logic [1:0]      drop_q, drop_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic [IdxW-1:0] r_start_q, r_start_d;
  logic [IdxW-1:0] s_start_q, s_start_d;
  logic            err_q, err_d;
  logic            bank_q, bank_d;

  logic            accept;
  logic [7:0]      exp_tag;
  phase_e          tag_next;
  phase_e          len_next;
  logic [15:0]     acc_shift;
  logic [7:0]      int_drop;
  logic [7:0]      int_kept;
  logic [7:0]      int_end;
  logic [IdxW-1:0] int_start;
  logic            len_bad;

  // A bank is free unless two signatures are already queued
  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && !job_full_i;

  // Expected tag and successor for tag and step-into length phases
  always_comb begin
    exp_tag  = TagSeq;
    tag_next = PH_OUT_LEN;
    len_next = PH_SKIP_TAG;
    case (phase_q)
      PH_OUT_TAG:  begin exp_tag = TagSeq;    tag_next = PH_OUT_LEN;  end
      PH_SKIP_TAG: begin exp_tag = TagSeq;    tag_next = PH_SKIP_LEN; end
      PH_OCT_TAG:  begin exp_tag = TagOctets; tag_next = PH_OCT_LEN;  end
      PH_IN_TAG:   begin exp_tag = TagSeq;    tag_next = PH_IN_LEN;   end
      PH_R_TAG:    begin exp_tag = TagInt;    tag_next = PH_R_LEN;    end
      PH_S_TAG:    begin exp_tag = TagInt;    tag_next = PH_S_LEN;    end
      PH_OUT_LEN:  len_next = PH_SKIP_TAG;
      PH_OCT_LEN:  len_next = PH_IN_TAG;
      PH_IN_LEN:   len_next = PH_R_TAG;
      default:     ;
    endcase
  end

  // Integer length decode: excess leading bytes beyond a half are dropped
  assign len_bad   = in_byte_i[7] || (in_byte_i == 8'd0) ||
                     (in_byte_i > 8'(HalfBytes + 2));
  assign int_drop  = (in_byte_i > 8'(HalfBytes)) ? (in_byte_i - 8'(HalfBytes)) : 8'd0;
  assign int_kept  = in_byte_i - int_drop;
  assign int_end   = (phase_q == PH_R_LEN) ? 8'(HalfBytes) : 8'(SigBytes);
  assign int_start = IdxW'(int_end - int_kept);
  assign acc_shift = {acc_q[7:0], in_byte_i};

  // Next state
  always_comb begin
    phase_d    = phase_q;
    rem_d      = rem_q;
    acc_d      = acc_q;
    drop_d     = drop_q;
    widx_d     = widx_q;
    r_start_d  = r_start_q;
    s_start_d  = s_start_q;
    err_d      = err_q;
    bank_d     = bank_q;
    wr_o.en    = 1'b0;
    wr_o.addr  = {bank_q, widx_q};
    wr_o.data  = in_byte_i;
    job_push_o = 1'b0;
    job_o.err     = 1'b0;
    job_o.bank    = bank_q;
    job_o.r_start = r_start_q;
    job_o.s_start = s_start_q;

    if (accept) begin
      case (phase_q)
        PH_OUT_TAG, PH_SKIP_TAG, PH_OCT_TAG, PH_IN_TAG, PH_R_TAG, PH_S_TAG: begin
          // pending skipped bytes are consumed first
          if (rem_q != 16'd0) begin
            rem_d = rem_q - 16'd1;
          end else if (in_byte_i != exp_tag) begin
            err_d   = 1'b1;
            phase_d = PH_END;
          end else begin
            phase_d = tag_next;
          end
        end
        PH_OUT_LEN, PH_OCT_LEN, PH_IN_LEN: begin
          rem_d   = (in_byte_i >= LongForm) ? {12'd0, in_byte_i[3:0] & LenNibble[3:0]}
                                            : 16'd0;
          phase_d = len_next;
        end
        PH_SKIP_LEN: begin
          if (in_byte_i < LongForm) begin
            rem_d   = {8'd0, in_byte_i};
            phase_d = PH_OCT_TAG;
          end else if ((in_byte_i & LenNibble) == 8'd1 ||
                       (in_byte_i & LenNibble) == 8'd2) begin
            acc_d   = 16'd0;
            drop_d  = in_byte_i[1:0];
            phase_d = PH_SKIP_LENB;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_END;
          end
        end
        PH_SKIP_LENB: begin
          drop_d = drop_q - 2'd1;
          if (drop_q == 2'd1) begin
            rem_d   = acc_shift;
            acc_d   = 16'd0;
            phase_d = PH_OCT_TAG;
          end else begin
            acc_d = acc_shift;
          end
        end
        PH_R_LEN, PH_S_LEN: begin
          if (len_bad) begin
            err_d   = 1'b1;
            phase_d = PH_END;
          end else begin
            drop_d = int_drop[1:0];
            widx_d = int_start;
            rem_d  = {8'd0, in_byte_i};
            acc_d  = {8'd0, in_byte_i};
            if (phase_q == PH_R_LEN) begin
              r_start_d = int_start;
              phase_d   = PH_R_BODY;
            end else begin
              s_start_d = int_start;
              phase_d   = PH_S_BODY;
            end
          end
        end
        PH_R_BODY, PH_S_BODY: begin
          // an over-long value must open with a zero byte
          if (rem_q == acc_q && drop_q != 2'd0 && in_byte_i != 8'd0) begin
            err_d   = 1'b1;
            phase_d = PH_END;
          end else begin
            if (drop_q != 2'd0) begin
              drop_d = drop_q - 2'd1;
            end else begin
              wr_o.en = 1'b1;
              widx_d  = widx_q + 1'b1;
            end
            rem_d = rem_q - 16'd1;
            if (rem_q == 16'd1) begin
              acc_d   = 16'd0;
              phase_d = (phase_q == PH_R_BODY) ? PH_S_TAG : PH_END;
            end
          end
        end
        default: ;
      endcase

      // Last byte: queue the job and start over in the other bank
      if (in_last_i) begin
        job_push_o = 1'b1;
        job_o.err  = err_d || (phase_d != PH_END);
        phase_d    = PH_OUT_TAG;
        rem_d      = 16'd0;
        acc_d      = 16'd0;
        drop_d     = 2'd0;
        widx_d     = '0;
        err_d      = 1'b0;
        bank_d     = !bank_q;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OUT_TAG;
      rem_q   <= 16'd0;
      acc_q   <= 16'd0;
      drop_q  <= 2'd0;
      widx_q  <= '0;
      err_q   <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      drop_q  <= drop_d;
      widx_q  <= widx_d;
      err_q   <= err_d;
      bank_q  <= bank_d;
    end
  end

  // Start indexes of r and s (read only for complete signatures)
  always_ff @(posedge clk_i) begin
    r_start_q <= r_start_d;
    s_start_q <= s_start_d;
  end

endmodule

// ----- sv/edr_job_fifo.sv -----
// ============================================================================
// edr_job_fifo
// Two-entry queue of finished signatures between parser and emitter.
// ============================================================================
module edr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  edr_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output edr_pkg::job_t head_o
);
  import edr_pkg::*;

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- sv/edr_emitter.sv -----
// ============================================================================
// edr_emitter
// Back end: drains one queued signature, reading its bank in order and
// padding unwritten leading bytes with zero, or sends one error item.
// ============================================================================
module edr_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  edr_pkg::job_t   job_i,
  output logic            job_pop_o,
  output edr_pkg::ram_rd_t rd_o,
  input  logic [7:0]      rdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            status_o
);
  import edr_pkg::*;

  logic [IdxW-1:0] k_q, k_d;
  logic            rd_v_q, rd_v_d;
  logic            rd_pad_q, rd_last_q;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;
  logic            status_q, status_d;

  logic            can_load;
  logic            issue;
  logic            err_load;
  logic            last_k;
  logic            pad;

  // Output register free now or after this cycle's transaction
  assign can_load = !out_valid_q || out_ready_i;
  assign issue    = job_valid_i && !job_i.err && (!rd_v_q || can_load);
  assign err_load = job_valid_i && job_i.err && !rd_v_q && can_load;
  assign last_k   = (k_q == IdxW'(SigBytes - 1));
  assign pad      = (k_q < IdxW'(HalfBytes)) ? (k_q < job_i.r_start)
                                              : (k_q < job_i.s_start);

  assign job_pop_o = err_load || (issue && last_k);
  assign rd_o.en   = issue;
  assign rd_o.addr = {job_i.bank, k_q};

  // Next state
  always_comb begin
    k_d         = k_q;
    rd_v_d      = rd_v_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    status_d    = status_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    // move read data into the output register
    if (rd_v_q && can_load) begin
      rd_v_d      = 1'b0;
      out_valid_d = 1'b1;
      out_byte_d  = rd_pad_q ? 8'd0 : rdata_i;
      out_last_d  = rd_last_q;
      status_d    = 1'b0;
    end
    if (err_load) begin
      out_valid_d = 1'b1;
      out_byte_d  = 8'd0;
      out_last_d  = 1'b1;
      status_d    = 1'b1;
    end
    if (issue) begin
      rd_v_d = 1'b1;
      k_d    = last_k ? '0 : k_q + 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_pad_q  <= pad;
      rd_last_q <= last_k;
    end
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    status_q   <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign status_o    = status_q;

endmodule
